[sv/afd_pkg.sv]
// afd_pkg: widths, codes and helpers shared by the fall detector files
// depends on nothing
package afd_pkg;

  localparam int ADC_BITS  = 10;
  localparam int FRAC_BITS = 4;
  localparam int MAG_W     = 15;
  localparam int THR_W     = 11;
  localparam int WIN_W     = 8;
  localparam int CNT_W     = 8;
  localparam int SQ_W      = 2 * ADC_BITS;
  localparam int SUMSQ_W   = SQ_W + 2;
  localparam int ROOT_W    = 16;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int ROOT_CYCLES = ROOT_W / 2;
  localparam int STEP_W    = $clog2(ROOT_CYCLES);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = THR_W;

  localparam logic [THR_W-1:0] THR_RESET  = THR_W'(50);
  localparam logic [WIN_W-1:0] WIN_RESET  = WIN_W'(50);
  localparam logic [MAG_W-1:0] PREV_RESET = MAG_W'(1000 << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] CFG_FALL_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 1'd1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic       load;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       sq_last;
    logic       root_en;
    logic       fin;
  } afd_cmd_t;

  typedef struct packed {
    logic close;
    logic out_free;
  } afd_status_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // one restoring square root digit
  function automatic sqrt_t sqrt_step(sqrt_t s, logic [1:0] pair);
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    sqrt_t r;
    cur   = {s.rem[REM_W-3:0], pair};
    trial = {s.root, 2'b01};
    if (cur >= trial) begin
      r.rem  = cur - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = cur;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[sv/afd_if.sv]
// afd_sample_if, afd_result_if: valid/ready channels of the fall detector
// depends on afd_pkg
interface afd_sample_if import afd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] accel_x;
  logic [ADC_BITS-1:0] accel_y;
  logic [ADC_BITS-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface afd_result_if import afd_pkg::*;;
  logic             valid;
  logic             ready;
  logic             fall_detected;
  logic [MAG_W-1:0] filtered_magnitude;
  logic [MAG_W-1:0] magnitude_change;

  modport source (output valid, fall_detected, filtered_magnitude, magnitude_change,
                  input ready);
  modport sink (input valid, fall_detected, filtered_magnitude, magnitude_change,
                output ready);
endinterface

[sv/afd_ctrl.sv]
// afd_ctrl: sequencer for load, square, root and finish steps
// depends on afd_pkg
module afd_ctrl import afd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  afd_status_t st_i,
  output afd_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SQR  = 2'd1;
  localparam logic [1:0] S_ROOT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQR;
          step_d     = '0;
        end
      end
      S_SQR: begin
        cmd_o.sq_en   = 1'b1;
        cmd_o.sq_sel  = step_q[1:0];
        cmd_o.sq_last = (step_q[1:0] == AXIS_Z);
        if (step_q[1:0] == AXIS_Z) begin
          state_d = S_ROOT;
          step_d  = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_ROOT: begin
        cmd_o.root_en = 1'b1;
        if (step_q == STEP_W'(ROOT_CYCLES - 1)) begin
          state_d = S_FIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      S_FIN: begin
        if (!st_i.close || st_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

[sv/afd_datapath.sv]
// afd_datapath: squares, square root, window filter, config and result register
// depends on afd_pkg
module afd_datapath import afd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  afd_cmd_t              cmd_i,
  output afd_status_t           st_o,
  input  logic [ADC_BITS-1:0]   accel_x_i,
  input  logic [ADC_BITS-1:0]   accel_y_i,
  input  logic [ADC_BITS-1:0]   accel_z_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  fall_detected_o,
  output logic [MAG_W-1:0]      filtered_magnitude_o,
  output logic [MAG_W-1:0]      magnitude_change_o
);

  logic [THR_W-1:0]    thr_q;
  logic [WIN_W-1:0]    win_q;
  logic [ADC_BITS-1:0] x_q, y_q, z_q;
  logic [SUMSQ_W-1:0]  sumsq_q, sumsq_d;
  logic [RAD_W-1:0]    rad_q;
  sqrt_t               sq_q, sq_mid, sq_d;
  logic [MAG_W-1:0]    filt_q, prev_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                out_valid_q;
  logic                fall_q;
  logic [MAG_W-1:0]    filt_out_q, chg_out_q;

  logic [ADC_BITS-1:0] axis;
  logic [SQ_W-1:0]     square;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W:0]      fsum;
  logic [MAG_W-1:0]    filt_new;
  logic [MAG_W-1:0]    diff;
  logic [MAG_W-1:0]    thr_fix;
  logic [WIN_W-1:0]    len;
  logic [CNT_W:0]      cnt_inc;
  logic                close;

  always_comb begin
    unique case (cmd_i.sq_sel)
      AXIS_X:  axis = x_q;
      AXIS_Y:  axis = y_q;
      default: axis = z_q;
    endcase
  end

  assign square  = axis * axis;
  assign sumsq_d = sumsq_q + SUMSQ_W'(square);

  assign sq_mid = sqrt_step(sq_q, rad_q[RAD_W-1 -: 2]);
  assign sq_d   = sqrt_step(sq_mid, rad_q[RAD_W-3 -: 2]);

  assign mag      = sq_q.root[MAG_W-1:0];
  assign fsum     = {1'b0, filt_q} + {1'b0, mag};
  assign filt_new = fsum[MAG_W:1];
  assign diff     = (filt_new >= prev_q) ? (filt_new - prev_q) : (prev_q - filt_new);
  assign thr_fix  = MAG_W'({thr_q, {FRAC_BITS{1'b0}}});
  assign len      = (win_q == '0) ? WIN_W'(1) : win_q;
  assign cnt_inc  = {1'b0, cnt_q} + (CNT_W+1)'(1);
  assign close    = cnt_inc >= (CNT_W+1)'(len);

  assign st_o.close    = close;
  assign st_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THR_RESET;
      win_q       <= WIN_RESET;
      filt_q      <= '0;
      prev_q      <= PREV_RESET;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FALL_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
          default:            win_q <= cfg_data_i[WIN_W-1:0];
        endcase
      end
      if (cmd_i.fin && close) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.fin) begin
        if (close) begin
          prev_q <= filt_new;
          filt_q <= '0;
          cnt_q  <= '0;
        end else begin
          filt_q <= filt_new;
          cnt_q  <= cnt_inc[CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= accel_x_i;
      y_q     <= accel_y_i;
      z_q     <= accel_z_i;
      sumsq_q <= '0;
    end
    if (cmd_i.sq_en) begin
      sumsq_q <= sumsq_d;
      if (cmd_i.sq_last) begin
        rad_q <= RAD_W'({sumsq_d, {(2 * FRAC_BITS){1'b0}}});
        sq_q  <= '0;
      end
    end
    if (cmd_i.root_en) begin
      sq_q  <= sq_d;
      rad_q <= {rad_q[RAD_W-5:0], 4'b0000};
    end
    if (cmd_i.fin && close) begin
      fall_q     <= diff > thr_fix;
      filt_out_q <= filt_new;
      chg_out_q  <= diff;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign fall_detected_o      = fall_q;
  assign filtered_magnitude_o = filt_out_q;
  assign magnitude_change_o   = chg_out_q;

endmodule

[sv/accel_fall_detector.sv]
// accel_fall_detector: top level, joins sequencer and datapath
// depends on afd_pkg, afd_if, afd_ctrl, afd_datapath
//
// Takes one three-axis accelerometer sample per item and returns one result
// item at the end of each window of window_length samples, holding the
// window's filtered magnitude (4 fraction bits), its absolute change from the
// previous window and a fall flag. Each item passes through an accept cycle,
// a single shared 10x10 multiplier for the sum of squares, one axis at a time,
// the square root unit resolving two root bits per cycle, and a finishing
// cycle for the filter, before the next item can be taken. On a window's
// closing sample the finishing cycle waits while the previous result item is
// still held in the output register. The result item appears in the cycle
// after that finishing cycle.
module accel_fall_detector import afd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  afd_sample_if.sink            sample_i,
  afd_result_if.source          result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  afd_cmd_t    cmd;
  afd_status_t st;
  logic        in_ready;

  assign sample_i.ready = in_ready;

  afd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (in_ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  afd_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .st_o                 (st),
    .accel_x_i            (sample_i.accel_x),
    .accel_y_i            (sample_i.accel_y),
    .accel_z_i            (sample_i.accel_z),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .out_valid_o          (result_o.valid),
    .out_ready_i          (result_o.ready),
    .fall_detected_o      (result_o.fall_detected),
    .filtered_magnitude_o (result_o.filtered_magnitude),
    .magnitude_change_o   (result_o.magnitude_change)
  );

endmodule

[sv/afd_checker.sv]
// afd_checker: port-level assertions for accel_fall_detector, with its bind
// depends on afd_pkg
module afd_checker import afd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             fall_i,
  input logic [MAG_W-1:0] filt_i,
  input logic [MAG_W-1:0] chg_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(fall_i) && $stable(filt_i) && $stable(chg_i))
    else $error("result item changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while busy");

  // result only comes out as the block returns to idle
  a_result_at_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i && !$past(in_ready_i))
    else $error("result item outside finishing step");

  // a fall needs a nonzero change
  a_fall_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fall_i |-> chg_i != '0)
    else $error("fall flagged with zero change");

endmodule

bind accel_fall_detector afd_checker u_afd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .fall_i      (result_o.fall_detected),
  .filt_i      (result_o.filtered_magnitude),
  .chg_i       (result_o.magnitude_change)
);

[dv/accel_fall_detector_tb.sv]
// accel_fall_detector_tb: self-checking bench for the accelerometer fall detector
// predicts each window result from the accepted samples and checks the result items
// depends on afd_pkg, afd_if and the accel_fall_detector rtl
module accel_fall_detector_tb;
  import afd_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;

  typedef struct {
    logic             fall;
    logic [MAG_W-1:0] filtered;
    logic [MAG_W-1:0] change;
  } window_result_t;

  class fall_scoreboard;
    logic [THR_W-1:0] threshold;
    logic [WIN_W-1:0] win_len;
    logic [MAG_W-1:0] filt_acc;
    logic [MAG_W-1:0] prev_window;
    logic [CNT_W-1:0] count;
    window_result_t   due[$];
    int               errors;

    function new();
      threshold   = 11'd50;
      win_len     = 8'd50;
      filt_acc    = '0;
      prev_window = 15'(1000 << FRAC_BITS);
      count       = '0;
      errors      = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("ERROR: %0t %s", $realtime, msg);
    endfunction

    function logic [15:0] root_floor(logic [31:0] v);
      logic [15:0] r;
      logic [15:0] t;
      r = '0;
      for (int b = 15; b >= 0; b--) begin
        t = r | (16'd1 << b);
        if ({16'd0, t} * {16'd0, t} <= v) r = t;
      end
      return r;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FALL_THRESHOLD: threshold = data[THR_W-1:0];
        CFG_WINDOW_LENGTH:  win_len = data[WIN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [ADC_BITS-1:0] x, logic [ADC_BITS-1:0] y,
                              logic [ADC_BITS-1:0] z);
      logic [31:0]      sumsq;
      logic [15:0]      mag;
      logic [16:0]      acc;
      logic [WIN_W-1:0] len;
      logic [MAG_W-1:0] diff;
      window_result_t   r;
      sumsq = 32'(x) * 32'(x) + 32'(y) * 32'(y) + 32'(z) * 32'(z);
      mag   = root_floor(sumsq << (2 * FRAC_BITS));
      len   = (win_len == '0) ? WIN_W'(1) : win_len;
      if (count == '0) filt_acc = '0;
      acc      = 17'(filt_acc) + 17'(mag);
      filt_acc = acc[MAG_W:1];
      count    = count + 1'b1;
      if (count != '0 && count < len) return;
      diff = (filt_acc >= prev_window) ? filt_acc - prev_window : prev_window - filt_acc;
      r.fall     = (32'(diff) > (32'(threshold) << FRAC_BITS));
      r.filtered = filt_acc;
      r.change   = diff;
      due.push_back(r);
      prev_window = filt_acc;
      filt_acc    = '0;
      count       = '0;
    endfunction

    function void check_result(logic fall, logic [MAG_W-1:0] filtered,
                               logic [MAG_W-1:0] change);
      window_result_t r;
      if (due.size() == 0) begin
        report($sformatf("result item with none expected: fall %b filt %0d chg %0d",
                         fall, filtered, change));
        return;
      end
      r = due.pop_front();
      if (fall !== r.fall)
        report($sformatf("fall_detected %b, expected %b", fall, r.fall));
      if (filtered !== r.filtered)
        report($sformatf("filtered_magnitude %0d, expected %0d", filtered, r.filtered));
      if (change !== r.change)
        report($sformatf("magnitude_change %0d, expected %0d", change, r.change));
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void close_out();
      if (due.size() != 0)
        report($sformatf("%0d expected result items never came", due.size()));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int unsigned           send_idle = 0;
  int unsigned           recv_stall = 0;
  logic                  hold_off = 1'b0;
  fall_scoreboard        board = new();

  afd_sample_if sample_bus();
  afd_result_if result_bus();

  accel_fall_detector uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_bus),
    .result_o   (result_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    result_bus.ready = !hold_off && ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
      board.check_result(result_bus.fall_detected, result_bus.filtered_magnitude,
                         result_bus.magnitude_change);
  end

  // tasks below start and end at a falling edge
  task automatic send_sample(input logic [ADC_BITS-1:0] x, input logic [ADC_BITS-1:0] y,
                             input logic [ADC_BITS-1:0] z);
    while ($urandom_range(99) < send_idle) @(negedge clk_i);
    sample_bus.valid   = 1'b1;
    sample_bus.accel_x = x;
    sample_bus.accel_y = y;
    sample_bus.accel_z = z;
    do @(posedge clk_i); while (sample_bus.ready !== 1'b1);
    board.note_sample(x, y, z);
    @(negedge clk_i);
    sample_bus.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = CFG_DATA_W'(val);
    @(posedge clk_i);
    board.set_reg(idx, cfg_data_i);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic settle();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_sample();
    logic [ADC_BITS-1:0] a[3];
    int unsigned         k;
    k = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (k < 55) a[i] = ADC_BITS'($urandom_range(1023));
      else if (k < 70) a[i] = $urandom_range(1) ? '1 : '0;
      else if (k < 90) a[i] = ADC_BITS'($urandom_range(540, 480));
      else a[i] = ADC_BITS'($urandom_range(15));
    end
    send_sample(a[0], a[1], a[2]);
  endtask

  task automatic run_segment(input int n);
    int unsigned k;
    int unsigned win;
    int unsigned thr;
    k = $urandom_range(99);
    if (k < 10) win = 0;
    else if (k < 70) win = $urandom_range(4, 1);
    else if (k < 90) win = $urandom_range(12, 5);
    else win = $urandom_range(40, 13);
    k = $urandom_range(99);
    if (k < 10) thr = 0;
    else if (k < 20) thr = 2047;
    else thr = $urandom_range(400);
    settle();
    write_reg(CFG_WINDOW_LENGTH, win);
    write_reg(CFG_FALL_THRESHOLD, thr);
    repeat (n) random_sample();
  endtask

  initial begin
    sample_bus.valid   = 1'b0;
    sample_bus.accel_x = '0;
    sample_bus.accel_y = '0;
    sample_bus.accel_z = '0;
    result_bus.ready   = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // field extremes, one window per item
    write_reg(CFG_FALL_THRESHOLD, 0);
    write_reg(CFG_WINDOW_LENGTH, 1);
    send_sample(0, 0, 0);
    send_sample(1023, 1023, 1023);
    send_sample(1023, 0, 0);
    send_sample(0, 1023, 0);
    send_sample(0, 0, 1023);
    send_sample(1, 1, 1);
    send_sample(1023, 1023, 1023);

    // zero window length behaves as one
    settle();
    write_reg(CFG_WINDOW_LENGTH, 0);
    send_sample(682, 341, 1023);
    send_sample(1023, 1023, 1023);

    // top threshold never flags
    settle();
    write_reg(CFG_FALL_THRESHOLD, 2047);
    write_reg(CFG_WINDOW_LENGTH, 3);
    repeat (3) random_sample();

    // window shortened below and onto the running count
    settle();
    write_reg(CFG_FALL_THRESHOLD, 30);
    write_reg(CFG_WINDOW_LENGTH, 10);
    repeat (4) random_sample();
    settle();
    write_reg(CFG_WINDOW_LENGTH, 2);
    random_sample();
    settle();
    write_reg(CFG_WINDOW_LENGTH, 6);
    repeat (3) random_sample();
    settle();
    write_reg(CFG_WINDOW_LENGTH, 3);
    random_sample();

    // change equal to threshold is not a fall, one step above is
    settle();
    write_reg(CFG_FALL_THRESHOLD, 5);
    write_reg(CFG_WINDOW_LENGTH, 1);
    send_sample(0, 0, 0);
    send_sample(10, 0, 0);
    send_sample(0, 0, 0);
    send_sample(11, 0, 0);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        default: begin send_idle = 26; recv_stall = 26; end
      endcase
      repeat (4) run_segment(8);
    end

    // longest window
    send_idle  = 0;
    recv_stall = 0;
    settle();
    write_reg(CFG_WINDOW_LENGTH, 255);
    write_reg(CFG_FALL_THRESHOLD, $urandom_range(300));
    repeat (255) random_sample();

    // output held off long enough to back up the input
    settle();
    write_reg(CFG_WINDOW_LENGTH, 1);
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join_none
    repeat (24) random_sample();

    settle();
    board.close_out();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
